// ===== rtl/evg_pkg.sv =====
// Package for the ellipse vertex generator: sizes, constants, sequencer states,
// the CORDIC arctangent table and the output round/saturate function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package evg_pkg;

    // Request and vertex field widths.
    localparam int RADIUS_W     = 16;
    localparam int SEG_W        = 7;
    localparam int INDEX_W      = 6;
    localparam int POS_W        = 17;

    // Core sizing.
    localparam int MAX_SEGMENTS = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int PHASE_BITS   = 16;
    localparam int STEP_W       = 5;
    localparam int DCNT_W       = $clog2(PHASE_BITS);

    // Rotor is signed Q3.16, angle is an unsigned 2^32 turn fraction.
    localparam int ROT_W        = 20;
    localparam int ANG_W        = 30;
    localparam int Z_W          = 34;
    localparam int PROD_W       = POS_W + ROT_W;

    localparam logic signed [ROT_W-1:0] ROTOR_START = ROT_W'(39797);
    localparam int                      OUT_LIMIT   = 65535;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_ROT  = 6'b000100,
        S_MULX = 6'b001000,
        S_MULY = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    // Arctangent of 2^-k as a fraction of 2^32 per turn, rounded.
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458908;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Q20.16 product rounded half up to a Q16.0 integer and clamped to +-OUT_LIMIT.
    function automatic logic [POS_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]    s;
        logic signed [PROD_W-16:0] v;
        logic [POS_W-1:0]          r;
        s = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(32768));
        v = s[PROD_W:16];
        if (v > $signed((PROD_W-15)'(OUT_LIMIT))) begin
            r = POS_W'(OUT_LIMIT);
        end else if (v < -$signed((PROD_W-15)'(OUT_LIMIT))) begin
            r = POS_W'(-OUT_LIMIT);
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/evg_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on a shared
// add/shift datapath. Depends on evg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evg_cordic (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_start,
    input  wire  [evg_pkg::ANG_W-1:0]               i_angle,
    output logic                                    o_done,
    output logic signed [evg_pkg::ROT_W-1:0]        o_cos,
    output logic signed [evg_pkg::ROT_W-1:0]        o_sin
);
    import evg_pkg::*;

    logic signed [ROT_W-1:0] r_x, n_x;
    logic signed [ROT_W-1:0] r_y, n_y;
    logic signed [Z_W-1:0]   r_z, n_z;
    logic [STEP_W-1:0]       r_k, n_k;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;

    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic signed [Z_W-1:0]   da;

    // One micro-rotation: floor shifts of the rotor and a table step of angle.
    always_comb begin
        dx     = r_y >>> r_k;
        dy     = r_x >>> r_k;
        da     = $signed({{(Z_W-32){1'b0}}, atan_turn(r_k)});
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_k    = r_k;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = ROTOR_START;
            n_y    = '0;
            n_z    = $signed({{(Z_W-ANG_W){1'b0}}, i_angle});
            n_k    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_z[Z_W-1]) begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - da;
            end else begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + da;
            end
            n_k = r_k + 1'b1;
            if (r_k == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_k <= n_k;
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule

`default_nettype wire

// ===== rtl/ellipse_vertex_generator_top.sv =====
// Ellipse vertex generator top level: request intake, phase divider, quadrant
// fold, shared multiplier, output register. Depends on evg_pkg and evg_cordic.
// Each vertex runs through the phase divider, the CORDIC rotation and the
// multiply and emit states in turn; a request with a count of zero emits no
// vertex. One request at a time. Reset is synchronous, active low, and returns
// to idle.
`timescale 1ns / 1ps
`default_nettype none

module ellipse_vertex_generator_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [evg_pkg::RADIUS_W-1:0]        i_radius_x,
    input  wire  [evg_pkg::RADIUS_W-1:0]        i_radius_y,
    input  wire  [evg_pkg::SEG_W-1:0]           i_segment_count,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic signed [evg_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [evg_pkg::POS_W-1:0]    o_pos_y,
    output logic [evg_pkg::INDEX_W-1:0]         o_point_index,
    output logic                                o_last_point
);
    import evg_pkg::*;

    t_state                   r_state, n_state;
    logic [RADIUS_W-1:0]      r_rx, n_rx;
    logic [RADIUS_W-1:0]      r_ry, n_ry;
    logic [SEG_W-1:0]         r_n, n_n;
    logic [SEG_W-1:0]         r_i, n_i;
    logic [SEG_W-1:0]         r_rem, n_rem;
    logic [PHASE_BITS-1:0]    r_quo, n_quo;
    logic [DCNT_W-1:0]        r_dcnt, n_dcnt;
    logic signed [ROT_W-1:0]  r_cx, n_cx;
    logic signed [ROT_W-1:0]  r_sy, n_sy;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [POS_W-1:0]         r_px, n_px;

    logic                     r_ov, n_ov;
    logic [POS_W-1:0]         r_ox, n_ox;
    logic [POS_W-1:0]         r_oy, n_oy;
    logic [INDEX_W-1:0]       r_oi, n_oi;
    logic                     r_ol, n_ol;

    logic [SEG_W-1:0]         seg_sat;
    logic [SEG_W:0]           div_trial;
    logic                     div_bit;
    logic [PHASE_BITS-1:0]    quo_next;
    logic                     cor_start;
    logic [ANG_W-1:0]         cor_angle;
    logic                     cor_done;
    logic signed [ROT_W-1:0]  cor_cos;
    logic signed [ROT_W-1:0]  cor_sin;
    logic signed [RADIUS_W:0] mul_a;
    logic signed [ROT_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     out_free;

    // Counts above the maximum are clamped.
    assign seg_sat = (i_segment_count > SEG_W'(MAX_SEGMENTS)) ?
                     SEG_W'(MAX_SEGMENTS) : i_segment_count;

    // One restoring division step of (i << PHASE_BITS) / n.
    assign div_trial = {r_rem, 1'b0};
    assign div_bit   = (div_trial >= {1'b0, r_n});
    assign quo_next  = {r_quo[PHASE_BITS-2:0], div_bit};

    // The low quarter-turn of the phase feeds the rotator as a 2^32 fraction.
    assign cor_start = (r_state == S_DIV) && (r_dcnt == DCNT_W'(PHASE_BITS - 1));
    assign cor_angle = {quo_next[PHASE_BITS-3:0], {(32 - PHASE_BITS){1'b0}}};

    evg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // Shared multiplier: radius times folded cos or sin.
    always_comb begin
        if (r_state == S_MULX) begin
            mul_a = $signed({1'b0, r_rx});
            mul_b = r_cx;
        end else begin
            mul_a = $signed({1'b0, r_ry});
            mul_b = r_sy;
        end
        mul_p = mul_a * mul_b;
    end

    assign out_free = !r_ov || i_ready;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_n     = r_n;
        n_i     = r_i;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dcnt  = r_dcnt;
        n_cx    = r_cx;
        n_sy    = r_sy;
        n_prod  = r_prod;
        n_px    = r_px;
        n_ov    = r_ov && !i_ready;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_oi    = r_oi;
        n_ol    = r_ol;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rx   = i_radius_x;
                    n_ry   = i_radius_y;
                    n_n    = seg_sat;
                    n_i    = '0;
                    n_rem  = '0;
                    n_quo  = '0;
                    n_dcnt = '0;
                    if (seg_sat != '0) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_quo  = quo_next;
                n_rem  = div_bit ? SEG_W'(div_trial - {1'b0, r_n}) : div_trial[SEG_W-1:0];
                n_dcnt = r_dcnt + 1'b1;
                if (cor_start) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                // Fold the quadrant back onto the first-quadrant result.
                if (cor_done) begin
                    case (r_quo[PHASE_BITS-1 -: 2])
                        2'd0: begin
                            n_cx = cor_cos;
                            n_sy = cor_sin;
                        end
                        2'd1: begin
                            n_cx = -cor_sin;
                            n_sy = cor_cos;
                        end
                        2'd2: begin
                            n_cx = -cor_cos;
                            n_sy = -cor_sin;
                        end
                        default: begin
                            n_cx = cor_sin;
                            n_sy = -cor_cos;
                        end
                    endcase
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                n_prod  = mul_p;
                n_state = S_MULY;
            end
            S_MULY: begin
                n_px    = round_sat(r_prod);
                n_prod  = mul_p;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Load the vertex once the output register is free.
                if (out_free) begin
                    n_ov = 1'b1;
                    n_ox = r_px;
                    n_oy = round_sat(r_prod);
                    n_oi = r_i[INDEX_W-1:0];
                    n_ol = (r_i + 1'b1 == r_n);
                    if (r_i + 1'b1 == r_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_rem   = r_i + 1'b1;
                        n_quo   = '0;
                        n_dcnt  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Registers: control state is reset, payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_n    <= n_n;
        r_i    <= n_i;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dcnt <= n_dcnt;
        r_cx   <= n_cx;
        r_sy   <= n_sy;
        r_prod <= n_prod;
        r_px   <= n_px;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_oi   <= n_oi;
        r_ol   <= n_ol;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_pos_x       = $signed(r_ox);
    assign o_pos_y       = $signed(r_oy);
    assign o_point_index = r_oi;
    assign o_last_point  = r_ol;

endmodule

`default_nettype wire
